[rtl/pool3d_max_avg_assert.svh]
// Assertion macros for the pool3d_max_avg RTL (used by p3d_back).
// Needs clk_i and rst_ni in the scope of the module that uses them.
`ifndef POOL3D_MAX_AVG_ASSERT_SVH
`define POOL3D_MAX_AVG_ASSERT_SVH

// Clocked check, disabled while reset is asserted.
`define P3D_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Implication from a condition to a check in the next cycle.
`define P3D_ASSERT_NEXT(label, cond, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (cond) |=> (prop)) \
    else $error(msg);

`endif

[rtl/p3d_pkg.sv]
// Package for the 3D pooling block: widths, mode codes, back-end states, queue entry type.
// No dependencies.
`default_nettype none
package p3d_pkg;
  localparam int DATA_W = 16;
  localparam int IDX_W  = 10;
  localparam int SUM_W  = 25;
  localparam int CNT_W  = 10;
  localparam int WORD_W = SUM_W + CNT_W + DATA_W;
  localparam int DEPTH  = 1 << IDX_W;

  typedef enum logic [1:0] {
    MODE_AVG  = 2'd0,
    MODE_MAX  = 2'd1,
    MODE_ZERO = 2'd2
  } mode_e;

  typedef enum logic [2:0] {
    B_IDLE = 3'd0,
    B_UPD  = 3'd1,
    B_DIV  = 3'd2,
    B_OUT  = 3'd3
  } back_state_e;

  // One classified element on its way to the back end
  typedef struct packed {
    logic [IDX_W-1:0]         idx;
    logic                     fresh;
    logic signed [DATA_W-1:0] x;
    logic                     emit;
    logic                     last;
    mode_e                    mode;
  } entry_t;
endpackage
`default_nettype wire

[rtl/pool3d_max_avg.sv]
// Non-overlapping 3D max / average pooling over a streamed tensor.
//
// Channels: s_axis_* takes one tensor element per beat in raster order,
// inner index fastest. m_axis_* gives one pooled value per window when the
// window's last element has been taken; tlast marks the tensor's final one.
// cfg_* writes registers 0..6 (dims outer/middle/inner, windows
// outer/middle/inner, mode); writing one restarts the stream at position zero.
// An accepted element is registered into the queue. Per element the back
// end reads the store (IDLE) and writes it back (UPD); a max or zero result
// then passes OUT, an average DIV (the one-bit-per-cycle divider) and OUT.
// It takes no new element before the last is done, so throughput is bounded
// by the store read-modify-write and, when a window ends, by the divider.
// The per-window store is cleared logically through a fill count at the
// start of each window plane, so no clearing pass is needed.
// Reset clears positions, queue and output; registers return to defaults.
// A stalled receiver holds the output beat; the queue then fills and
// s_axis_tready drops until the beat is taken.
// Depends on p3d_pkg, p3d_front, p3d_fifo, p3d_back.
`default_nettype none
module pool3d_max_avg (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        cfg_valid_i,
  output logic             cfg_ready_o,
  input  wire logic [2:0]  cfg_index_i,
  input  wire logic [8:0]  cfg_data_i,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [15:0] s_axis_tdata,   // [15:0] sample_value
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [15:0]      m_axis_tdata,   // [15:0] pooled_value
  output logic             m_axis_tlast    // tensor_done
);
  p3d_pkg::entry_t push_ent, head_ent;
  logic push, pop, full, empty, accept;

  assign cfg_ready_o   = 1'b1;
  assign s_axis_tready = !full;
  assign accept        = s_axis_tvalid && !full;

  p3d_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_valid_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .accept_i    (accept),
    .sample_i    (s_axis_tdata),
    .push_o      (push),
    .entry_o     (push_ent)
  );

  p3d_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .data_i  (push_ent),
    .pop_i   (pop),
    .data_o  (head_ent),
    .full_o  (full),
    .empty_o (empty)
  );

  p3d_back u_back (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .head_i    (head_ent),
    .empty_i   (empty),
    .pop_o     (pop),
    .m_valid_o (m_axis_tvalid),
    .m_ready_i (m_axis_tready),
    .m_data_o  (m_axis_tdata),
    .m_last_o  (m_axis_tlast)
  );
endmodule
`default_nettype wire

[rtl/p3d_fifo.sv]
// Two-entry queue between the front and back ends.
// Depends on p3d_pkg.
`default_nettype none
module p3d_fifo (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            push_i,
  input  wire p3d_pkg::entry_t data_i,
  input  wire logic            pop_i,
  output p3d_pkg::entry_t      data_o,
  output logic                 full_o,
  output logic                 empty_o
);
  p3d_pkg::entry_t slot_q [2];
  logic       wp_q, rp_q;
  logic [1:0] cnt_q;

  assign full_o  = cnt_q[1];
  assign empty_o = (cnt_q == 2'd0);
  assign data_o  = slot_q[rp_q];

  // storage
  always_ff @(posedge clk_i) begin
    if (push_i) slot_q[wp_q] <= data_i;
  end

  // pointers and fill
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= 1'b0;
      rp_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      if (push_i) wp_q <= ~wp_q;
      if (pop_i) rp_q <= ~rp_q;
      if (push_i && !pop_i) cnt_q <= cnt_q + 2'd1;
      else if (pop_i && !push_i) cnt_q <= cnt_q - 2'd1;
    end
  end
endmodule
`default_nettype wire

[rtl/p3d_front.sv]
// Front end: configuration registers, position tracking, window index and
// fill-count bookkeeping. Depends on p3d_pkg.
`default_nettype none
module p3d_front (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 cfg_we_i,
  input  wire logic [2:0]           cfg_index_i,
  input  wire logic [8:0]           cfg_data_i,
  input  wire logic                 accept_i,
  input  wire logic [15:0]          sample_i,
  output logic                      push_o,
  output p3d_pkg::entry_t           entry_o
);
  localparam logic [2:0] CFG_DIM_O = 3'd0;
  localparam logic [2:0] CFG_DIM_M = 3'd1;
  localparam logic [2:0] CFG_DIM_I = 3'd2;
  localparam logic [2:0] CFG_WIN_O = 3'd3;
  localparam logic [2:0] CFG_WIN_M = 3'd4;
  localparam logic [2:0] CFG_WIN_I = 3'd5;
  localparam logic [2:0] CFG_MODE  = 3'd6;
  localparam logic [10:0] FULL_HW  = 11'(p3d_pkg::DEPTH);

  logic [8:0] dim_o_q, dim_m_q, dim_i_q;
  logic [3:0] win_o_q, win_m_q, win_i_q;
  logic [1:0] mode_q;

  logic [7:0]  pos_o_q, pos_m_q, pos_i_q;
  logic [2:0]  sub_o_q, sub_m_q, sub_i_q;
  logic [7:0]  wi_q;
  logic [15:0] base_q;
  logic [10:0] hw_q;

  logic [7:0]  dl_o, dl_m, dl_i;
  logic [2:0]  wl_o, wl_m, wl_i;
  logic        pe_o, pe_m, pe_i, we_o, we_m, we_i;
  logic        plane_start;
  logic [10:0] hw_eff, hw_d;
  logic [15:0] raw;
  logic        valid_ent;

  // clamped limits, as last index
  function automatic logic [7:0] dim_last(logic [8:0] v);
    logic [8:0] c;
    c = (v == 9'd0) ? 9'd1 : ((v > 9'd256) ? 9'd256 : v);
    return 8'(c - 9'd1);
  endfunction

  function automatic logic [2:0] win_last(logic [3:0] v);
    logic [3:0] c;
    c = (v == 4'd0) ? 4'd1 : ((v > 4'd8) ? 4'd8 : v);
    return 3'(c - 4'd1);
  endfunction

  always_comb begin
    dl_o = dim_last(dim_o_q);
    dl_m = dim_last(dim_m_q);
    dl_i = dim_last(dim_i_q);
    wl_o = win_last(win_o_q);
    wl_m = win_last(win_m_q);
    wl_i = win_last(win_i_q);
    pe_o = (pos_o_q == dl_o);
    pe_m = (pos_m_q == dl_m);
    pe_i = (pos_i_q == dl_i);
    we_o = (sub_o_q == wl_o);
    we_m = (sub_m_q == wl_m);
    we_i = (sub_i_q == wl_i);
    plane_start = (pos_i_q == 8'd0) && (pos_m_q == 8'd0) && (sub_o_q == 3'd0);
    hw_eff = plane_start ? 11'd0 : hw_q;
    raw = base_q + {8'd0, wi_q};
    // entry holds data of this plane if its raw index was already reached
    valid_ent = hw_eff[10] || ({1'b0, raw[9:0]} < hw_eff);
    if (raw >= 16'(p3d_pkg::DEPTH - 1)) hw_d = FULL_HW;
    else if (11'(raw + 16'd1) > hw_eff) hw_d = 11'(raw + 16'd1);
    else hw_d = hw_eff;
  end

  always_comb begin
    push_o        = accept_i;
    entry_o.idx   = raw[p3d_pkg::IDX_W-1:0];
    entry_o.fresh = ~valid_ent;
    entry_o.x     = sample_i;
    entry_o.emit  = (we_o || pe_o) && (we_m || pe_m) && (we_i || pe_i);
    entry_o.last  = pe_o && pe_m && pe_i;
    case (mode_q)
      p3d_pkg::MODE_AVG: entry_o.mode = p3d_pkg::MODE_AVG;
      p3d_pkg::MODE_MAX: entry_o.mode = p3d_pkg::MODE_MAX;
      default:           entry_o.mode = p3d_pkg::MODE_ZERO;
    endcase
  end

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dim_o_q <= 9'd1;
      dim_m_q <= 9'd1;
      dim_i_q <= 9'd1;
      win_o_q <= 4'd1;
      win_m_q <= 4'd1;
      win_i_q <= 4'd1;
      mode_q  <= p3d_pkg::MODE_AVG;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        CFG_DIM_O: dim_o_q <= cfg_data_i;
        CFG_DIM_M: dim_m_q <= cfg_data_i;
        CFG_DIM_I: dim_i_q <= cfg_data_i;
        CFG_WIN_O: win_o_q <= cfg_data_i[3:0];
        CFG_WIN_M: win_m_q <= cfg_data_i[3:0];
        CFG_WIN_I: win_i_q <= cfg_data_i[3:0];
        CFG_MODE:  mode_q  <= cfg_data_i[1:0];
        default:   ;
      endcase
    end
  end

  // position walk; a valid config write restarts the stream
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_o_q <= '0; pos_m_q <= '0; pos_i_q <= '0;
      sub_o_q <= '0; sub_m_q <= '0; sub_i_q <= '0;
      wi_q    <= '0;
      base_q  <= '0;
      hw_q    <= '0;
    end else if (cfg_we_i && (cfg_index_i <= CFG_MODE)) begin
      pos_o_q <= '0; pos_m_q <= '0; pos_i_q <= '0;
      sub_o_q <= '0; sub_m_q <= '0; sub_i_q <= '0;
      wi_q    <= '0;
      base_q  <= '0;
    end else if (accept_i) begin
      hw_q <= hw_d;
      if (!pe_i) begin
        pos_i_q <= pos_i_q + 8'd1;
        if (we_i) begin
          sub_i_q <= '0;
          wi_q    <= wi_q + 8'd1;
        end else begin
          sub_i_q <= sub_i_q + 3'd1;
        end
      end else begin
        pos_i_q <= '0;
        sub_i_q <= '0;
        wi_q    <= '0;
        if (!pe_m) begin
          pos_m_q <= pos_m_q + 8'd1;
          if (we_m) begin
            sub_m_q <= '0;
            base_q  <= base_q + {8'd0, wi_q} + 16'd1;
          end else begin
            sub_m_q <= sub_m_q + 3'd1;
          end
        end else begin
          pos_m_q <= '0;
          sub_m_q <= '0;
          base_q  <= '0;
          if (!pe_o) begin
            pos_o_q <= pos_o_q + 8'd1;
            sub_o_q <= we_o ? 3'd0 : sub_o_q + 3'd1;
          end else begin
            pos_o_q <= '0;
            sub_o_q <= '0;
          end
        end
      end
    end
  end
endmodule
`default_nettype wire

[rtl/p3d_div.sv]
// Restoring divider: 25-bit signed sum by 10-bit count, one bit per cycle,
// truncated toward zero and clamped to 16 bits. Depends on p3d_pkg.
`default_nettype none
module p3d_div (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  input  wire logic                              start_i,
  input  wire logic signed [p3d_pkg::SUM_W-1:0]  sum_i,
  input  wire logic [p3d_pkg::CNT_W-1:0]         cnt_i,
  output logic                                   done_o,
  output logic signed [p3d_pkg::DATA_W-1:0]      quot_o
);
  localparam int SW = p3d_pkg::SUM_W;
  localparam int CW = p3d_pkg::CNT_W;

  logic [SW-1:0] dvd_q;
  logic [CW-1:0] rem_q, den_q;
  logic          neg_q, busy_q, done_q;
  logic [4:0]    step_q;
  logic [CW:0]   rem_sh;
  logic          take;
  logic [SW:0]   sum_ext;

  always_comb begin
    rem_sh  = {rem_q, dvd_q[SW-1]};
    take    = (rem_sh >= {1'b0, den_q});
    sum_ext = {sum_i[SW-1], sum_i};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      step_q <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        step_q <= '0;
      end else if (busy_q) begin
        step_q <= step_q + 5'd1;
        if (step_q == 5'(SW - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  // datapath
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      neg_q <= sum_i[SW-1];
      dvd_q <= SW'(sum_i[SW-1] ? -sum_ext : sum_ext);
      den_q <= cnt_i;
      rem_q <= '0;
    end else if (busy_q) begin
      rem_q <= take ? CW'(rem_sh - {1'b0, den_q}) : rem_sh[CW-1:0];
      dvd_q <= {dvd_q[SW-2:0], take};
    end
  end

  // sign and clamp
  always_comb begin
    done_o = done_q;
    if (!neg_q && (dvd_q > SW'(32767)))      quot_o = 16'sh7fff;
    else if (neg_q && (dvd_q > SW'(32768)))  quot_o = -16'sh8000;
    else if (neg_q)                          quot_o = 16'(-dvd_q);
    else                                     quot_o = 16'(dvd_q);
  end
endmodule
`default_nettype wire

[rtl/p3d_back.sv]
// Back end: per-window store read-modify-write, result selection, divider
// control and output register. Depends on p3d_pkg, p3d_div, assert header.
`default_nettype none
`include "pool3d_max_avg_assert.svh"
module p3d_back (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire p3d_pkg::entry_t       head_i,
  input  wire logic                  empty_i,
  output logic                       pop_o,
  output logic                       m_valid_o,
  input  wire logic                  m_ready_i,
  output logic [15:0]                m_data_o,
  output logic                       m_last_o
);
  localparam int SW = p3d_pkg::SUM_W;
  localparam int CW = p3d_pkg::CNT_W;
  localparam int DW = p3d_pkg::DATA_W;
  localparam logic signed [SW:0] SUM_HI = (SW+1)'((1 << (SW-1)) - 1);
  localparam logic signed [SW:0] SUM_LO = -(SW+1)'(1 << (SW-1));

  logic [p3d_pkg::WORD_W-1:0] mem_q [p3d_pkg::DEPTH];
  logic [p3d_pkg::WORD_W-1:0] rd_q, wdata;

  p3d_pkg::back_state_e state_q, state_d;
  p3d_pkg::entry_t      ent_q;

  logic                  we, div_start, load_out, div_done;
  logic signed [SW-1:0]  s0, s_new;
  logic [CW-1:0]         c0, c_new;
  logic signed [DW-1:0]  m0, m_new, div_q;
  logic signed [SW:0]    s_ext;
  logic signed [DW-1:0]  res_q;
  logic                  out_valid_q, out_last_q;
  logic [15:0]           out_data_q;

  // stored word update
  always_comb begin
    s0 = ent_q.fresh ? '0 : rd_q[p3d_pkg::WORD_W-1 -: SW];
    c0 = ent_q.fresh ? '0 : rd_q[DW +: CW];
    m0 = rd_q[DW-1:0];
    m_new = ((c0 == '0) || (ent_q.x > m0)) ? ent_q.x : m0;
    s_ext = {s0[SW-1], s0} + (SW+1)'(ent_q.x);
    if (s_ext > SUM_HI)      s_new = SW'(SUM_HI);
    else if (s_ext < SUM_LO) s_new = SW'(SUM_LO);
    else                     s_new = SW'(s_ext);
    c_new = (c0 == '1) ? c0 : c0 + CW'(1);
    wdata = {s_new, c_new, m_new};
  end

  // store
  always_ff @(posedge clk_i) begin
    if (we) mem_q[ent_q.idx] <= wdata;
    if (pop_o) rd_q <= mem_q[head_i.idx];
  end

  p3d_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .sum_i   (s_new),
    .cnt_i   (c_new),
    .done_o  (div_done),
    .quot_o  (div_q)
  );

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      p3d_pkg::B_IDLE: if (!empty_i) state_d = p3d_pkg::B_UPD;
      p3d_pkg::B_UPD: begin
        if (!ent_q.emit) state_d = p3d_pkg::B_IDLE;
        else if (ent_q.mode == p3d_pkg::MODE_AVG) state_d = p3d_pkg::B_DIV;
        else state_d = p3d_pkg::B_OUT;
      end
      p3d_pkg::B_DIV: if (div_done) state_d = p3d_pkg::B_OUT;
      p3d_pkg::B_OUT: if (!out_valid_q || m_ready_i) state_d = p3d_pkg::B_IDLE;
      default: state_d = p3d_pkg::B_IDLE;
    endcase
  end

  // state outputs
  always_comb begin
    pop_o     = 1'b0;
    we        = 1'b0;
    div_start = 1'b0;
    load_out  = 1'b0;
    case (state_q)
      p3d_pkg::B_IDLE: pop_o = !empty_i;
      p3d_pkg::B_UPD: begin
        we        = 1'b1;
        div_start = ent_q.emit && (ent_q.mode == p3d_pkg::MODE_AVG);
      end
      p3d_pkg::B_OUT: load_out = !out_valid_q || m_ready_i;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= p3d_pkg::B_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (load_out) out_valid_q <= 1'b1;
      else if (m_ready_i) out_valid_q <= 1'b0;
    end
  end

  // payload
  always_ff @(posedge clk_i) begin
    if (pop_o) ent_q <= head_i;
    if (state_q == p3d_pkg::B_UPD) begin
      res_q <= (ent_q.mode == p3d_pkg::MODE_MAX) ? m_new : '0;
    end else if (state_q == p3d_pkg::B_DIV && div_done) begin
      res_q <= div_q;
    end
    if (load_out) begin
      out_data_q <= res_q;
      out_last_q <= ent_q.last;
    end
  end

  assign m_valid_o = out_valid_q;
  assign m_data_o  = out_data_q;
  assign m_last_o  = out_last_q;

  `P3D_ASSERT(a_pop_nonempty, pop_o |-> !empty_i, "pop from empty queue")
  `P3D_ASSERT(a_load_free, load_out |-> (!out_valid_q || m_ready_i), "output overwritten")
  `P3D_ASSERT_NEXT(a_div_follow, div_start, state_q == p3d_pkg::B_DIV, "divider not awaited")
  `P3D_ASSERT(a_done_in_div, div_done |-> (state_q == p3d_pkg::B_DIV), "stray divider done")
endmodule
`default_nettype wire

[verif/tb.sv]
// Self-checking testbench for pool3d_max_avg: stream stimulus, config writes,
// and a cycle-free predictor of the pooled results. Depends on p3d_pkg and the RTL.
`timescale 1ns / 1ps
`default_nettype none
module tb;
  typedef enum logic [2:0] {
    REG_DIM_O = 3'd0, REG_DIM_M = 3'd1, REG_DIM_I = 3'd2,
    REG_WIN_O = 3'd3, REG_WIN_M = 3'd4, REG_WIN_I = 3'd5,
    REG_MODE  = 3'd6, REG_NONE  = 3'd7
  } reg_idx_e;

  localparam int TAIL_CYCLES = 64;

  typedef struct {
    logic signed [15:0] value;
    logic               done;
  } pooled_t;

  // one directed step: either a register write or a sample beat
  typedef struct {
    bit           is_cfg;
    reg_idx_e     idx;
    logic [15:0]  data;
    bit           typed;
    logic [15:0]  exp_value;
    bit           exp_done;
  } step_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        cfg_valid_i = 1'b0;
  logic        cfg_ready_o;
  logic [2:0]  cfg_index_i = '0;
  logic [8:0]  cfg_data_i = '0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [15:0] s_axis_tdata = '0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [15:0] m_axis_tdata;
  logic        m_axis_tlast;

  pool3d_max_avg i_dut (.*);

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  // predictor state
  logic [8:0]         pool_regs [7];
  longint             win_sum   [p3d_pkg::DEPTH];
  int unsigned        win_cnt   [p3d_pkg::DEPTH];
  logic signed [15:0] win_max   [p3d_pkg::DEPTH];
  int unsigned        at_o, at_m, at_i;
  pooled_t            pending_q [$];
  int                 errors = 0;
  int                 mismatches = 0;
  bit                 calm = 1'b0;
  int                 sent = 0;

  function automatic int unsigned clip(int unsigned v, int unsigned hi);
    if (v < 1) return 1;
    if (v > hi) return hi;
    return v;
  endfunction

  function automatic void model_cfg(reg_idx_e idx, logic [8:0] data);
    int w;
    if (idx == REG_NONE) return;
    w = (idx <= REG_DIM_I) ? 9 : (idx == REG_MODE) ? 2 : 4;
    pool_regs[idx] = data & ((9'd1 << w) - 1);
    at_o = 0; at_m = 0; at_i = 0;
  endfunction

  // advances the window state by one element; returns 1 when a window closes
  function automatic bit pool_sample(logic signed [15:0] x, output pooled_t res);
    int unsigned d_o, d_m, d_i, w_o, w_m, w_i, nwin, idx;
    bit end_o, end_m, end_i;
    longint r;
    d_o = clip(pool_regs[REG_DIM_O], 256); d_m = clip(pool_regs[REG_DIM_M], 256);
    d_i = clip(pool_regs[REG_DIM_I], 256); w_o = clip(pool_regs[REG_WIN_O], 8);
    w_m = clip(pool_regs[REG_WIN_M], 8);   w_i = clip(pool_regs[REG_WIN_I], 8);
    if (at_o >= d_o) at_o = 0;
    if (at_m >= d_m) at_m = 0;
    if (at_i >= d_i) at_i = 0;
    // new window plane clears sums and counts
    if (at_i == 0 && at_m == 0 && (at_o % w_o) == 0) begin
      foreach (win_sum[k]) begin
        win_sum[k] = 0;
        win_cnt[k] = 0;
      end
    end
    nwin = (d_i + w_i - 1) / w_i;
    idx = ((at_m / w_m) * nwin + at_i / w_i) % p3d_pkg::DEPTH;
    if (win_cnt[idx] == 0 || x > win_max[idx]) win_max[idx] = x;
    win_sum[idx] += x;
    if (win_sum[idx] > 16777215) win_sum[idx] = 16777215;
    if (win_sum[idx] < -16777216) win_sum[idx] = -16777216;
    if (win_cnt[idx] < 1023) win_cnt[idx]++;
    end_o = ((at_o + 1) % w_o) == 0 || at_o + 1 == d_o;
    end_m = ((at_m + 1) % w_m) == 0 || at_m + 1 == d_m;
    end_i = ((at_i + 1) % w_i) == 0 || at_i + 1 == d_i;
    res.done = (at_o + 1 == d_o) && (at_m + 1 == d_m) && (at_i + 1 == d_i);
    r = 0;
    if (pool_regs[REG_MODE] == p3d_pkg::MODE_AVG) begin
      r = win_sum[idx] / longint'(win_cnt[idx]);
      if (r > 32767) r = 32767;
      if (r < -32768) r = -32768;
    end else if (pool_regs[REG_MODE] == p3d_pkg::MODE_MAX) begin
      r = win_max[idx];
    end
    res.value = r[15:0];
    at_i++;
    if (at_i >= d_i) begin
      at_i = 0;
      at_m++;
      if (at_m >= d_m) begin
        at_m = 0;
        at_o++;
        if (at_o >= d_o) at_o = 0;
      end
    end
    return end_o && end_m && end_i;
  endfunction

  function automatic bit idle_roll();
    return !calm && ($urandom_range(99) < 8);
  endfunction

  // register write, only once the block has drained
  task automatic cfg_write(reg_idx_e idx, logic [8:0] data);
    s_axis_tvalid <= 1'b0;
    wait (pending_q.size() == 0);
    repeat (TAIL_CYCLES) @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    model_cfg(idx, data);
    cfg_valid_i <= 1'b0;
  endtask

  // one sample beat; a typed expectation overrides the predicted one
  task automatic send_sample(logic [15:0] v, bit typed = 0, logic [15:0] ev = '0,
                             bit ed = 0);
    pooled_t res;
    while (idle_roll()) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= v;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    sent++;
    if (pool_sample(v, res)) begin
      if (typed) begin
        res.value = ev;
        res.done  = ed;
      end
      pending_q.push_back(res);
    end
  endtask

  function automatic logic [15:0] rand_sample();
    case ($urandom_range(5))
      0: return 16'h7FFF;
      1: return 16'h8000;
      2: return 16'($urandom_range(511)) - 16'd256;
      default: return 16'($urandom);
    endcase
  endfunction

  // result checker
  always @(posedge clk_i) begin
    m_axis_tready <= calm || ($urandom_range(99) >= 8);
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (pending_q.size() == 0) begin
        errors++;
        mismatches++;
        if (mismatches <= 10) $display("unexpected beat: value %h done %b",
                                       m_axis_tdata, m_axis_tlast);
      end else begin
        pooled_t e;
        e = pending_q.pop_front();
        if (e.value !== m_axis_tdata || e.done !== m_axis_tlast) begin
          errors++;
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: exp value %h done %b, got value %h done %b",
                     e.value, e.done, m_axis_tdata, m_axis_tlast);
        end
      end
    end
  end

  step_t steps [] = '{
    // after reset every element is its own window
    '{0, REG_NONE, 16'h7FFF, 1, 16'h7FFF, 1},
    '{0, REG_NONE, 16'h8000, 1, 16'h8000, 1},
    '{0, REG_NONE, 16'h0000, 1, 16'h0000, 1},
    '{0, REG_NONE, 16'h0001, 1, 16'h0001, 1},
    '{0, REG_NONE, 16'hFFFF, 1, 16'hFFFF, 1},
    // zero mode and the unused mode code
    '{1, REG_MODE, 16'd2, 0, 0, 0},
    '{0, REG_NONE, 16'h1234, 1, 16'h0000, 1},
    '{1, REG_MODE, 16'd3, 0, 0, 0},
    '{0, REG_NONE, 16'h8000, 1, 16'h0000, 1},
    // partial edge window in max mode
    '{1, REG_MODE, 16'd1, 0, 0, 0},
    '{1, REG_DIM_I, 16'd3, 0, 0, 0},
    '{1, REG_WIN_I, 16'd2, 0, 0, 0},
    '{0, REG_NONE, 16'h0005, 0, 0, 0},
    '{0, REG_NONE, 16'hFFFD, 0, 0, 0},
    '{0, REG_NONE, 16'h0007, 0, 0, 0},
    // zero registers read as one
    '{1, REG_WIN_I, 16'd0, 0, 0, 0},
    '{1, REG_DIM_I, 16'd0, 0, 0, 0},
    '{0, REG_NONE, 16'h8001, 1, 16'h8001, 1},
    // nonexistent register is ignored
    '{1, REG_NONE, 16'h1FF, 0, 0, 0},
    // oversized registers saturate
    '{1, REG_DIM_I, 16'h1FF, 0, 0, 0},
    '{1, REG_WIN_I, 16'd15, 0, 0, 0},
    '{1, REG_MODE, 16'd0, 0, 0, 0},
    '{0, REG_NONE, 16'h7FFF, 0, 0, 0},
    '{0, REG_NONE, 16'h7FFF, 0, 0, 0},
    '{0, REG_NONE, 16'h8000, 0, 0, 0}
  };

  // main sequence
  initial begin
    int n;
    int unsigned vol;
    foreach (pool_regs[k]) pool_regs[k] = 9'd1;
    pool_regs[REG_MODE] = p3d_pkg::MODE_AVG;
    foreach (win_sum[k]) begin
      win_sum[k] = 0;
      win_cnt[k] = 0;
      win_max[k] = '0;
    end
    at_o = 0; at_m = 0; at_i = 0;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (steps[k]) begin
      if (steps[k].is_cfg) cfg_write(steps[k].idx, steps[k].data[8:0]);
      else send_sample(steps[k].data, steps[k].typed, steps[k].exp_value,
                       steps[k].exp_done);
    end

    // random tensors, mostly small
    sent = 0;
    while (sent < 450) begin
      cfg_write(REG_DIM_O, 9'($urandom_range(1, 5)));
      cfg_write(REG_DIM_M, 9'($urandom_range(1, 7)));
      cfg_write(REG_DIM_I, 9'($urandom_range(1, 10)));
      cfg_write(REG_WIN_O, ($urandom_range(4) == 0) ? 9'd8 : 9'($urandom_range(1, 3)));
      cfg_write(REG_WIN_M, ($urandom_range(4) == 0) ? 9'd8 : 9'($urandom_range(1, 4)));
      cfg_write(REG_WIN_I, ($urandom_range(4) == 0) ? 9'd8 : 9'($urandom_range(1, 4)));
      cfg_write(REG_MODE, ($urandom_range(5) == 0) ? 9'($urandom_range(2, 3))
                                                  : 9'($urandom_range(1)));
      vol = clip(pool_regs[REG_DIM_O], 256) * clip(pool_regs[REG_DIM_M], 256) *
            clip(pool_regs[REG_DIM_I], 256);
      // usually whole tensors, sometimes cut short or run into the next one
      n = ($urandom_range(3) == 0) ? $urandom_range(1, 2 * vol) : vol;
      calm = (sent > 150 && sent < 260);
      for (int j = 0; j < n; j++) begin
        send_sample(rand_sample());
        if (sent == 300) begin
          s_axis_tvalid <= 1'b0;
          wait (pending_q.size() == 0);
          @(posedge clk_i);
        end
      end
    end
    calm = 1'b0;
    s_axis_tvalid <= 1'b0;

    wait (pending_q.size() == 0);
    repeat (TAIL_CYCLES) @(posedge clk_i);
    if (errors == 0) $display("tb OK");
    else $display("tb NOT OK");
    $finish;
  end

  // watchdog
  initial begin
    #50_000_000;
    $display("tb NOT OK");
    $finish;
  end
endmodule
`default_nettype wire
